/* design/esd_pkg.sv */
// Types, character constants and helper functions shared by the escape decoder.
package esd_pkg;

  // Decoder mode codes.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_OCT1   = 3'd2,
    MODE_OCT2   = 3'd3,
    MODE_HEX0   = 3'd4,
    MODE_HEX1   = 3'd5
  } mode_t;

  // Source characters with a special meaning.
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X         = 8'h78;
  localparam logic [7:0] CHAR_A         = 8'h61;
  localparam logic [7:0] CHAR_B         = 8'h62;
  localparam logic [7:0] CHAR_F         = 8'h66;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_V         = 8'h76;

  // Control codes produced by the simple escapes.
  localparam logic [7:0] CODE_BEL = 8'd7;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] CODE_HT  = 8'd9;
  localparam logic [7:0] CODE_VT  = 8'd11;

  // Depth of the queue between classifier and output stage.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // One result record.
  typedef struct packed {
    logic       vld;
    logic       close;
    logic [7:0] data;
    logic       err;
  } rec_t;

  // Up to two result records caused by one input item; r1 is used only with r0.
  typedef struct packed {
    rec_t r0;
    rec_t r1;
  } entry_t;

  // Octal digit: {is_digit, value}.
  function automatic logic [3:0] octal_digit(input logic [7:0] b);
    logic [3:0] res;
    res = 4'b0;
    if (b >= 8'h30 && b <= 8'h37) begin
      res = {1'b1, b[2:0]};
    end
    return res;
  endfunction

  // Hex digit: {is_digit, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] res;
    logic [7:0] diff;
    res  = 5'b0;
    diff = 8'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      diff = b - 8'h30;
      res  = {1'b1, diff[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      diff = b - 8'h37;
      res  = {1'b1, diff[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      diff = b - 8'h57;
      res  = {1'b1, diff[3:0]};
    end
    return res;
  endfunction

  // Simple escape letter: {is_simple, control code}.
  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] res;
    res = 9'b0;
    unique case (b)
      CHAR_A:  res = {1'b1, CODE_BEL};
      CHAR_B:  res = {1'b1, CODE_BS};
      CHAR_F:  res = {1'b1, CODE_FF};
      CHAR_N:  res = {1'b1, CODE_LF};
      CHAR_R:  res = {1'b1, CODE_CR};
      CHAR_T:  res = {1'b1, CODE_HT};
      CHAR_V:  res = {1'b1, CODE_VT};
      default: res = 9'b0;
    endcase
    return res;
  endfunction

  // Build a data byte record.
  function automatic rec_t byte_rec(input logic [7:0] d, input logic e);
    rec_t r;
    r.vld   = 1'b1;
    r.close = 1'b0;
    r.data  = d;
    r.err   = e;
    return r;
  endfunction

  // Build a closing record.
  function automatic rec_t close_rec(input logic e);
    rec_t r;
    r.vld   = 1'b1;
    r.close = 1'b1;
    r.data  = 8'h00;
    r.err   = e;
    return r;
  endfunction

endpackage

/* design/esd_if.sv */
// Valid/ready stream interfaces for the source characters and the decoded records.
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface esd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        closing_record;
  logic [15:0] total_length;
  logic        bad_escape;

  modport source (output valid, output out_byte, output closing_record,
                  output total_length, output bad_escape, input ready);
  modport sink   (input valid, input out_byte, input closing_record,
                  input total_length, input bad_escape, output ready);
endinterface

/* design/escape_sequence_decoder_core.sv */
// Top level of the C string escape decoder: classifier, queue and output stage.
//
// Use: source characters enter on in_ch (valid/ready), one byte per transfer,
// with end_of_string marking the end item of a string. Decoded records leave
// on out_ch: a data byte, or a closing record that carries the string's
// produced length (saturating at 65535) and the sticky bad_escape flag.
// Path: an accepted item's first record is written into the queue, then loaded
// from the queue head into the output register that drives out_ch.
// Throughput: one input item per cycle while the queue has room; an item that causes
// two records (a digit run ended by a plain character, or a flush before the closing
// record) sends them through the output register one after the other. The four-entry
// queue between classifier and output stage absorbs short runs of such items.
// Reset (rst, synchronous): decoder mode, pending value, error flag, queue and
// byte count clear; out_ch.valid drops.
// Stall: while out_ch.ready is low the output register holds its record, the
// queue fills, and in_ch.ready falls once the queue is full.
// LENGTH_LIMIT sets the saturation point of the internal byte counter.
module escape_sequence_decoder_core #(
  parameter longint unsigned LENGTH_LIMIT = 65535
) (
  input  logic       clk,
  input  logic       rst,
  esd_in_if.sink     in_ch,
  esd_out_if.source  out_ch
);
  import esd_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   head_valid;
  entry_t head_entry;
  logic   pop;

  esd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  esd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  esd_back #(
    .LENGTH_LIMIT (LENGTH_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

/* design/esd_front.sv */
// Front end: accepts source characters, tracks the escape mode and classifies results.
module esd_front (
  input  logic            clk,
  input  logic            rst,
  esd_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output esd_pkg::entry_t push_entry
);
  import esd_pkg::*;

  mode_t      mode, mode_next;
  logic [7:0] pend, pend_next;
  logic       err, err_next;
  logic       accept;
  entry_t     ent;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  // Decode one character against the current mode.
  always_comb begin
    logic       fall;
    logic [3:0] oct;
    logic [4:0] hex;
    logic [8:0] simp;
    logic [7:0] b;
    fall      = 1'b0;
    b         = in_ch.in_byte;
    oct       = octal_digit(b);
    hex       = hex_digit(b);
    simp      = simple_escape(b);
    mode_next = mode;
    pend_next = pend;
    err_next  = err;
    ent       = '0;

    if (in_ch.end_of_string) begin
      // Flush a pending value, then close and return to the reset state.
      if (mode == MODE_OCT1 || mode == MODE_OCT2 || mode == MODE_HEX1) begin
        ent.r0 = byte_rec(pend, err);
        ent.r1 = close_rec(err);
      end else if (mode == MODE_ESC || mode == MODE_HEX0) begin
        ent.r0 = close_rec(1'b1);
      end else begin
        ent.r0 = close_rec(err);
      end
      mode_next = MODE_NORMAL;
      pend_next = 8'h00;
      err_next  = 1'b0;
    end else begin
      unique case (mode)
        MODE_ESC: begin
          mode_next = MODE_NORMAL;
          if (simp[8]) begin
            ent.r0 = byte_rec(simp[7:0], err);
          end else if (b == CHAR_X) begin
            mode_next = MODE_HEX0;
          end else if (oct[3]) begin
            pend_next = {5'b0, oct[2:0]};
            mode_next = MODE_OCT1;
          end else begin
            ent.r0 = byte_rec(b, err);
          end
        end
        MODE_OCT1: begin
          if (oct[3]) begin
            pend_next = {pend[4:0], oct[2:0]};
            mode_next = MODE_OCT2;
          end else begin
            ent.r0 = byte_rec(pend, err);
            fall   = 1'b1;
          end
        end
        MODE_OCT2: begin
          if (oct[3]) begin
            ent.r0    = byte_rec({pend[4:0], oct[2:0]}, err);
            mode_next = MODE_NORMAL;
          end else begin
            ent.r0 = byte_rec(pend, err);
            fall   = 1'b1;
          end
        end
        MODE_HEX0: begin
          if (hex[4]) begin
            pend_next = {4'b0, hex[3:0]};
            mode_next = MODE_HEX1;
          end else begin
            err_next = 1'b1;
            fall     = 1'b1;
          end
        end
        MODE_HEX1: begin
          if (hex[4]) begin
            ent.r0    = byte_rec({pend[3:0], hex[3:0]}, err);
            mode_next = MODE_NORMAL;
          end else begin
            ent.r0 = byte_rec(pend, err);
            fall   = 1'b1;
          end
        end
        default: begin
          fall = 1'b1;
        end
      endcase

      // The character is handled as normal text.
      if (fall) begin
        mode_next = MODE_NORMAL;
        if (b == CHAR_BACKSLASH) begin
          mode_next = MODE_ESC;
        end else if (ent.r0.vld) begin
          ent.r1 = byte_rec(b, err_next);
        end else begin
          ent.r0 = byte_rec(b, err_next);
        end
      end
    end
  end

  assign push_valid = accept && ent.r0.vld;
  assign push_entry = ent;

  // Mode, pending value and sticky error.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      pend <= 8'h00;
      err  <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      pend <= pend_next;
      err  <= err_next;
    end
  end

  // An end item always leaves the decoder in its reset state.
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.end_of_string |=> mode == MODE_NORMAL && !err && pend == 8'h00)
    else $error("decoder state not cleared after end item");

endmodule

/* design/esd_queue.sv */
// Small FIFO of classified entries between the front end and the output stage.
module esd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  esd_pkg::entry_t push_entry,
  output logic            head_valid,
  output esd_pkg::entry_t head_entry,
  input  logic            pop
);
  import esd_pkg::*;

  entry_t                  slots [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QPTR_W:0]         count;
  logic                    push;

  assign push_ready = count != (QPTR_W+1)'(QDEPTH);
  assign push       = push_valid && push_ready;
  assign head_valid = count != '0;
  assign head_entry = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue fill count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

/* design/esd_back.sv */
// Output stage: counts produced bytes and sends records through an output register.
module esd_back #(
  parameter longint unsigned LENGTH_LIMIT = 65535
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  esd_pkg::entry_t head_entry,
  output logic            pop,
  esd_out_if.source       out_ch
);
  import esd_pkg::*;

  localparam int CountW = $clog2(LENGTH_LIMIT + 64'd1);
  localparam logic [CountW-1:0] Limit = CountW'(LENGTH_LIMIT);

  logic               sub;
  logic [CountW-1:0]  count;
  rec_t               cur;
  logic               last;
  logic               load;
  logic [CountW+15:0] count_wide;
  logic [15:0]        count_sat;

  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_close;
  logic [15:0]        out_len;
  logic               out_err;

  // Pick the record to send from the head entry.
  assign cur  = sub ? head_entry.r1 : head_entry.r0;
  assign last = sub || !head_entry.r1.vld;
  assign load = head_valid && (!out_valid || out_ch.ready);
  assign pop  = load && last;

  // Reported length saturates at the field's range.
  assign count_wide = {16'h0000, count};
  assign count_sat  = (count_wide > (CountW+16)'(17'h0FFFF)) ? 16'hFFFF : count_wide[15:0];

  // Record position, byte count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      sub       <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        sub       <= !last;
        out_valid <= 1'b1;
        if (cur.close) begin
          count <= '0;
        end else if (count < Limit) begin
          count <= count + 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= cur.data;
      out_close <= cur.close;
      out_len   <= cur.close ? count_sat : 16'h0000;
      out_err   <= cur.err;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.out_byte       = out_byte;
  assign out_ch.closing_record = out_close;
  assign out_ch.total_length   = out_len;
  assign out_ch.bad_escape     = out_err;

  a_close_resets_count: assert property (@(posedge clk) disable iff (rst)
    load && cur.close |=> count == '0)
    else $error("byte count not cleared after closing record");

  a_second_only_after_first: assert property (@(posedge clk) disable iff (rst)
    sub |-> head_valid && head_entry.r1.vld)
    else $error("second record selected without one queued");

endmodule
